// File: src/eam_pkg.sv
`timescale 1ns / 1ps
package eam_pkg;

  localparam int Iters = 18;
  localparam int ZW = 24;   // Q.20 angle width
  localparam int XW = 33;   // Q.30 CORDIC datapath width
  localparam int SW = 22;   // Q.20 sine/cosine width

  localparam logic signed [ZW-1:0] PiQ20     = 24'sd3294199;
  localparam logic signed [ZW-1:0] TwoPiQ20  = 24'sd6588397;
  localparam logic signed [ZW-1:0] HalfPiQ20 = 24'sd1647099;
  localparam logic signed [XW-1:0] GainQ30   = 33'sd652032874;

  localparam logic [1:0] REG_FIRST_AXIS = 2'd0;
  localparam logic [1:0] REG_PARITY     = 2'd1;
  localparam logic [1:0] REG_REPETITION = 2'd2;
  localparam logic [1:0] REG_FRAME      = 2'd3;

  typedef logic signed [ZW-1:0] ang_t;
  typedef logic signed [SW-1:0] trig_t;

  function automatic ang_t atan_q20(input int n);
    case (n)
      0: atan_q20 = 24'sd823550;
      1: atan_q20 = 24'sd486170;
      2: atan_q20 = 24'sd256879;
      3: atan_q20 = 24'sd130396;
      4: atan_q20 = 24'sd65451;
      5: atan_q20 = 24'sd32757;
      6: atan_q20 = 24'sd16383;
      default: atan_q20 = ang_t'(24'sd8192 >>> (n - 7));
    endcase
  endfunction

  function automatic logic [1:0] axis_after(input logic [1:0] a);
    case (a)
      2'd0: axis_after = 2'd1;
      2'd1: axis_after = 2'd2;
      2'd2: axis_after = 2'd0;
      default: axis_after = 2'd1;
    endcase
  endfunction

endpackage

// File: src/euler_angles_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// Euler angles (signed Q2.13 rad) to 3x3 rotation matrix (signed Q1.14) for
// any of the 24 axis sequences chosen by the four config registers. Fully
// pipelined: one word per cycle, through an input stage, the sine/cosine
// pipe, two multiply stages and sum/round into the output register.
// The whole pipe advances only when the output register can take a word, so
// backpressure stalls everything without loss. Write config only while idle.
module euler_angles_to_rotation_matrix_core import eam_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // angle_first, angle_second, angle_third
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // elem_r0_c0 .. elem_r2_c2, row-major
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [1:0]   cfg_data
);

  localparam int Lat = Iters + 6;
  localparam int MW = 44;   // two-factor product, Q.40
  localparam int PW = 66;   // three-factor product, Q.60

  logic [1:0] first_axis_r;
  logic       parity_r, rep_r, frame_r;
  logic       adv;
  logic [Lat-1:0] vld_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_axis_r <= '0;
      parity_r     <= 1'b0;
      rep_r        <= 1'b0;
      frame_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_AXIS: first_axis_r <= cfg_data;
        REG_PARITY:     parity_r     <= cfg_data[0];
        REG_REPETITION: rep_r        <= cfg_data[0];
        REG_FRAME:      frame_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Lat-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[Lat-1];

  // stage 0: swap, scale, negate
  ang_t a0, a1, a2, ai_r, aj_r, ak_r;
  assign a0 = ang_t'({{1{in_tdata[15]}}, in_tdata[15:0], 7'b0});
  assign a1 = ang_t'({{1{in_tdata[31]}}, in_tdata[31:16], 7'b0});
  assign a2 = ang_t'({{1{in_tdata[47]}}, in_tdata[47:32], 7'b0});
  always_ff @(posedge clk) begin
    if (adv) begin
      ai_r <= parity_r ? -(frame_r ? a2 : a0) : (frame_r ? a2 : a0);
      aj_r <= parity_r ? -a1 : a1;
      ak_r <= parity_r ? -(frame_r ? a0 : a2) : (frame_r ? a0 : a2);
    end
  end

  trig_t si, ci, sj, cj, sk, ck;
  eam_sincos u_sc_i (.clk(clk), .en(adv), .angle(ai_r), .sin_o(si), .cos_o(ci));
  eam_sincos u_sc_j (.clk(clk), .en(adv), .angle(aj_r), .sin_o(sj), .cos_o(cj));
  eam_sincos u_sc_k (.clk(clk), .en(adv), .angle(ak_r), .sin_o(sk), .cos_o(ck));

  // multiply stage 1: pair products (Q.40) and single factors kept at Q.40
  logic signed [MW-1:0] p_r [14];
  function automatic logic signed [MW-1:0] m2(input trig_t a, input trig_t b);
    m2 = MW'(a * b);
  endfunction
  function automatic logic signed [MW-1:0] up(input trig_t a);
    up = MW'(a) <<< 20;
  endfunction
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0]  <= m2(sj, si);  p_r[1]  <= m2(sj, ci);
      p_r[2]  <= m2(cj, si);  p_r[3]  <= m2(cj, ci);
      p_r[4]  <= m2(ci, ck);  p_r[5]  <= m2(si, ck);
      p_r[6]  <= m2(ci, sk);  p_r[7]  <= m2(si, sk);
      p_r[8]  <= up(cj);      p_r[9]  <= up(sj);
      p_r[10] <= up(ck);      p_r[11] <= up(sk);
      p_r[12] <= m2(cj, ck);  p_r[13] <= m2(cj, sk);
    end
  end
  trig_t ck2_r, sk2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ck2_r <= ck;
      sk2_r <= sk;
    end
  end

  // multiply stage 2: terms in Q.60
  logic signed [PW-1:0] t_r [9];
  logic signed [PW-1:0] u_r [9];
  function automatic logic signed [PW-1:0] m3(input logic signed [MW-1:0] a,
                                              input trig_t b);
    m3 = PW'(a * b);
  endfunction
  function automatic logic signed [PW-1:0] w1(input logic signed [MW-1:0] a);
    w1 = PW'(a) <<< 20;
  endfunction
  // slot order: ii ij ik ji jj jk ki kj kk
  always_ff @(posedge clk) begin
    if (adv) begin
      if (rep_r) begin
        t_r[0] <= w1(p_r[8]);            u_r[0] <= '0;
        t_r[1] <= w1(p_r[0]);            u_r[1] <= '0;
        t_r[2] <= w1(p_r[1]);            u_r[2] <= '0;
        t_r[3] <= m3(p_r[9], sk2_r);     u_r[3] <= '0;
        t_r[4] <= w1(p_r[4]);            u_r[4] <= -m3(p_r[2], sk2_r);
        t_r[5] <= -w1(p_r[5]);           u_r[5] <= -m3(p_r[3], sk2_r);
        t_r[6] <= -m3(p_r[9], ck2_r);    u_r[6] <= '0;
        t_r[7] <= w1(p_r[6]);            u_r[7] <= m3(p_r[2], ck2_r);
        t_r[8] <= -w1(p_r[7]);           u_r[8] <= m3(p_r[3], ck2_r);
      end else begin
        t_r[0] <= w1(p_r[12]);           u_r[0] <= '0;
        t_r[1] <= -w1(p_r[6]);           u_r[1] <= m3(p_r[0], ck2_r);
        t_r[2] <= w1(p_r[7]);            u_r[2] <= m3(p_r[1], ck2_r);
        t_r[3] <= w1(p_r[13]);           u_r[3] <= '0;
        t_r[4] <= w1(p_r[4]);            u_r[4] <= m3(p_r[0], sk2_r);
        t_r[5] <= -w1(p_r[5]);           u_r[5] <= m3(p_r[1], sk2_r);
        t_r[6] <= -w1(p_r[9]);           u_r[6] <= '0;
        t_r[7] <= w1(p_r[2]);            u_r[7] <= '0;
        t_r[8] <= w1(p_r[3]);            u_r[8] <= '0;
      end
    end
  end

  // axis permutation from the current config
  logic [1:0] ax_i, ax_j, ax_k;
  assign ax_i = (first_axis_r == 2'd3) ? 2'd0 : first_axis_r;
  assign ax_j = axis_after(ax_i + {1'b0, parity_r});
  assign ax_k = axis_after(ax_i + 2'd1 - {1'b0, parity_r});

  // sum, round, saturate, place
  logic [143:0] res_nxt, res_r;
  logic [1:0] ax [3];
  logic signed [PW-1:0] s;
  logic signed [PW-1:0] q;
  logic signed [15:0] e;
  assign ax[0] = ax_i;
  assign ax[1] = ax_j;
  assign ax[2] = ax_k;
  always_comb begin
    res_nxt = '0;
    s = '0;
    q = '0;
    e = '0;
    for (int n = 0; n < 9; n++) begin
      s = t_r[n] + u_r[n] + (PW'(1) <<< 45);
      q = s >>> 46;
      if (q > PW'(16384)) e = 16'sd16384;
      else if (q < -PW'(16384)) e = -16'sd16384;
      else e = q[15:0];
      res_nxt[(ax[n/3] * 3 + ax[n%3]) * 16 +: 16] = e;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end
  assign out_tdata = res_r;

endmodule

// File: src/eam_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine: one range-reduce stage, one CORDIC stage per step,
// one rounding stage. Takes one angle per cycle while en is high.
module eam_sincos import eam_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ang_t  angle,
  output trig_t sin_o,
  output trig_t cos_o
);

  logic signed [XW-1:0] x_r [Iters+1];
  logic signed [XW-1:0] y_r [Iters+1];
  ang_t                 z_r [Iters+1];
  logic                 f_r [Iters+1];
  ang_t  a1, a2;
  logic  flip;
  trig_t s_r, c_r;

  // reduce into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    a1 = angle;
    if (a1 > PiQ20) a1 = a1 - TwoPiQ20;
    if (a1 < -PiQ20) a1 = a1 + TwoPiQ20;
    flip = 1'b0;
    a2 = a1;
    if (a1 > HalfPiQ20) begin
      a2 = PiQ20 - a1;
      flip = 1'b1;
    end else if (a1 < -HalfPiQ20) begin
      a2 = -PiQ20 - a1;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GainQ30;
      y_r[0] <= '0;
      z_r[0] <= a2;
      f_r[0] <= flip;
    end
  end

  // one micro-rotation per stage
  for (genvar n = 0; n < Iters; n++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[n+1] <= f_r[n];
        if (!z_r[n][ZW-1]) begin
          x_r[n+1] <= x_r[n] - (y_r[n] >>> n);
          y_r[n+1] <= y_r[n] + (x_r[n] >>> n);
          z_r[n+1] <= z_r[n] - atan_q20(n);
        end else begin
          x_r[n+1] <= x_r[n] + (y_r[n] >>> n);
          y_r[n+1] <= y_r[n] - (x_r[n] >>> n);
          z_r[n+1] <= z_r[n] + atan_q20(n);
        end
      end
    end
  end

  // round Q.30 to Q.20
  logic signed [XW-1:0] ys, xs;
  assign ys = (y_r[Iters] + XW'(512)) >>> 10;
  assign xs = (x_r[Iters] + XW'(512)) >>> 10;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= ys[SW-1:0];
      c_r <= f_r[Iters] ? -xs[SW-1:0] : xs[SW-1:0];
    end
  end

  assign sin_o = s_r;
  assign cos_o = c_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb import eam_pkg::*; ();

  // one 3x3 rotation matrix, row-major, signed Q1.14
  typedef struct {
    logic signed [15:0] e [9];
  } matrix_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;   // angle_first, angle_second, angle_third
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;  // elem_r0_c0 .. elem_r2_c2
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [1:0]   cfg_data;

  euler_angles_to_rotation_matrix_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the axis-sequence registers
  logic [1:0] seq_axis;
  logic       seq_parity;
  logic       seq_repeat;
  logic       seq_frame;

  matrix_t matrix_q[$];
  int      err_count;
  int      word_count;
  int      matrix_count;
  int      hold_cycles;
  bit      hold_on;
  bit      burst_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sine/cosine of a Q.20 angle, results in Q.20
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, nx, at;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > 3294199) ang -= 6588397;
    if (ang < -3294199) ang += 6588397;
    if (ang > 1647099) begin
      ang = 3294199 - ang;
      flip = 1;
    end else if (ang < -1647099) begin
      ang = -3294199 - ang;
      flip = 1;
    end
    z = ang;
    for (int n = 0; n < 18; n++) begin
      case (n)
        0: at = 823550;
        1: at = 486170;
        2: at = 256879;
        3: at = 130396;
        4: at = 65451;
        5: at = 32757;
        6: at = 16383;
        default: at = 64'sd8192 >>> (n - 7);
      endcase
      if (z >= 0) begin
        nx = x - floor_shr(y, n);
        y = y + floor_shr(x, n);
        z -= at;
      end else begin
        nx = x + floor_shr(y, n);
        y = y - floor_shr(x, n);
        z += at;
      end
      x = nx;
    end
    s = floor_shr(y + 512, 10);
    c = floor_shr(x + 512, 10);
    if (flip) c = -c;
  endfunction

  // Q.60 sum to saturated Q1.14
  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    r = floor_shr(v + (64'sd1 <<< 45), 46);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic logic [1:0] nxt(logic [1:0] a);
    case (a)
      2'd0: return 2'd1;
      2'd1: return 2'd2;
      2'd2: return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic matrix_t rotation_of(logic [47:0] w);
    longint ai, aj, ak, t, si, sj, sk, ci, cj, ck;
    longint one;
    longint m [3][3];
    int i, j, k;
    matrix_t res;
    one = 1048576;
    ai = longint'($signed(w[15:0])) * 128;
    aj = longint'($signed(w[31:16])) * 128;
    ak = longint'($signed(w[47:32])) * 128;
    i = (seq_axis == 2'd3) ? 0 : seq_axis;
    j = nxt(2'(i + seq_parity));
    k = nxt(2'(i + 1 - seq_parity));
    if (seq_frame) begin
      t = ai;
      ai = ak;
      ak = t;
    end
    if (seq_parity) begin
      ai = -ai;
      aj = -aj;
      ak = -ak;
    end
    sin_cos(ai, si, ci);
    sin_cos(aj, sj, cj);
    sin_cos(ak, sk, ck);
    if (seq_repeat) begin
      m[i][i] = cj * one * one;
      m[i][j] = sj * si * one;
      m[i][k] = sj * ci * one;
      m[j][i] = sj * sk * one;
      m[j][j] = -(cj * si * sk) + ci * ck * one;
      m[j][k] = -(cj * ci * sk) - si * ck * one;
      m[k][i] = -(sj * ck * one);
      m[k][j] = cj * si * ck + ci * sk * one;
      m[k][k] = cj * ci * ck - si * sk * one;
    end else begin
      m[i][i] = cj * ck * one;
      m[i][j] = sj * si * ck - ci * sk * one;
      m[i][k] = sj * ci * ck + si * sk * one;
      m[j][i] = cj * sk * one;
      m[j][j] = sj * si * sk + ci * ck * one;
      m[j][k] = sj * ci * sk - si * ck * one;
      m[k][i] = -(sj * one * one);
      m[k][j] = cj * si * one;
      m[k][k] = cj * ci * one;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        res.e[r * 3 + c] = to_q14(m[r][c]);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at t=%0t: %s", $time, what);
    err_count++;
  endtask

  // register write, only while the pipe is empty; caller drops cfg_we
  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_FIRST_AXIS: seq_axis = val;
      REG_PARITY:     seq_parity = val[0];
      REG_REPETITION: seq_repeat = val[0];
      default:        seq_frame = val[0];
    endcase
  endtask

  task automatic set_sequence(logic [1:0] ax, logic p, logic r, logic f);
    write_reg(REG_FIRST_AXIS, ax);
    write_reg(REG_PARITY, {1'b0, p});
    write_reg(REG_REPETITION, {1'b0, r});
    write_reg(REG_FRAME, {1'b0, f});
    cfg_we <= 1'b0;
  endtask

  // drain: every expected matrix back, then pipe latency margin
  task automatic drain;
    in_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // send one word; random gap before it only in burst mode
  task automatic send_angles(logic [47:0] w);
    if (burst_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    matrix_q.push_back(rotation_of(w));
    word_count++;
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 25736) - 12868);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    logic [15:0] pts [8];
    pts = '{16'h0000, 16'h7fff, 16'h8000, 16'd12868, -16'sd12868, 16'd25736,
            -16'sd25736, 16'd6434};
    set_sequence(2'd0, 1'b0, 1'b0, 1'b0);
    for (int n = 0; n < 8; n++) send_angles({pts[7 - n], pts[(n + 3) % 8], pts[n]});
    drain();
    // first axis value 3 behaves as x; every flag set
    set_sequence(2'd3, 1'b1, 1'b1, 1'b1);
    for (int n = 0; n < 8; n++) send_angles({pts[n], pts[7 - n], pts[(n + 5) % 8]});
    send_angles(48'hffff_ffff_ffff);
    drain();
  endtask

  // all 24 sequences plus axis value 3, random angles
  task automatic test_all_sequences;
    for (int s = 0; s < 32; s++) begin
      set_sequence(s[4:3], s[2], s[1], s[0]);
      repeat (12) send_angles({rand_angle(), rand_angle(), rand_angle()});
      drain();
    end
  endtask

  // receiver holds off long while sender keeps offering words
  task automatic test_backpressure;
    set_sequence(2'd2, 1'b0, 1'b1, 1'b0);
    burst_mode = 0;
    hold_cycles = 80;
    hold_on = 1;
    repeat (50) send_angles({rand_angle(), rand_angle(), rand_angle()});
    burst_mode = 1;
    drain();
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_on) begin
      out_tready <= 1'b0;
      if (hold_cycles == 0) hold_on <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (burst_mode) begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_q.size() == 0) begin
        report_mismatch("matrix with none expected");
      end else begin
        matrix_t exp_m;
        exp_m = matrix_q.pop_front();
        matrix_count++;
        for (int n = 0; n < 9; n++)
          if (out_tdata[n * 16 +: 16] !== exp_m.e[n])
            report_mismatch($sformatf("elem r%0d c%0d got %0d want %0d", n / 3, n % 3,
                            $signed(out_tdata[n * 16 +: 16]), exp_m.e[n]));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    seq_axis = '0;
    seq_parity = 0;
    seq_repeat = 0;
    seq_frame = 0;
    err_count = 0;
    word_count = 0;
    matrix_count = 0;
    hold_on = 0;
    hold_cycles = 0;
    burst_mode = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_all_sequences();
    test_backpressure();
    // final random sequences at mixed settings
    repeat (2) begin
      set_sequence(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom));
      repeat (8) send_angles({rand_angle(), rand_angle(), rand_angle()});
      drain();
    end
    $display("sent %0d angle words, checked %0d matrices over all 24 axis sequences",
             word_count, matrix_count);
    $display("including axis value 3, extreme angles and a long output hold-off");
    if (err_count == 0 && matrix_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/eam_pkg.sv
src/eam_sincos.sv
src/euler_angles_to_rotation_matrix_core.sv
tb/tb.sv
